// ----- rtl/cdo_pkg.sv -----
// ----------------------------------------------------------------------------
// cdo_pkg
// Shared types, constants and calendar helpers for the date offset pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cdo_pkg;

    // calendar range
    localparam int YEAR_BASE     = 1900;
    localparam int LAST_YEAR     = 2155;
    localparam int SERIAL_MAX    = 131071;
    localparam int DAYS_PER_YEAR = 365;

    // port widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int OFFSET_W = 18;
    localparam int SERIAL_W = 17;
    localparam int STATUS_W = 2;

    // leap years counted up to and including a year n: n/4 - n/100 + n/400
    localparam int LU_BASE = (YEAR_BASE - 1) / 4 - (YEAR_BASE - 1) / 100
                           + (YEAR_BASE - 1) / 400;
    localparam int LU_LAST = LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400;

    // serial day of 31 Dec of the last year, clipped to what the port holds
    localparam int LAST_SERIAL_RAW = DAYS_PER_YEAR * (LAST_YEAR - YEAR_BASE + 1)
                                   + LU_LAST - LU_BASE;
    localparam int LAST_SERIAL = (LAST_SERIAL_RAW > SERIAL_MAX) ? SERIAL_MAX
                                                                : LAST_SERIAL_RAW;

    // floor(n / 100) as (n * DIV100_MUL) >> DIV100_SHIFT, exact for 12-bit n
    localparam int DIV100_MUL   = 41944;
    localparam int DIV100_SHIFT = 22;
    localparam int PROD100_W    = 28;
    localparam int Q100_W       = PROD100_W - DIV100_SHIFT;

    // floor(x / 365) as (x * DIV365_MUL) >> DIV365_SHIFT, exact for 17-bit x
    localparam int DIV365_MUL   = 91930;
    localparam int DIV365_SHIFT = 25;
    localparam int PROD365_W    = 34;
    localparam int YIDX_W       = PROD365_W - DIV365_SHIFT;

    // internal widths
    localparam int LU_W      = 11;  // leap counts and day-in-year partial sums
    localparam int YSERIAL_W = 20;  // serial day of any 12-bit year >= 1900
    localparam int SUM_W     = 22;  // signed serial plus offset
    localparam int YDAYS_W   = 18;  // days before the estimated output year
    localparam int DOY_W     = 9;   // day of year, 1..366

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    // serial plus offset, after the range check
    typedef struct packed {
        logic [SERIAL_W-1:0] sum;
        status_t             status;
    } cdo_sum_t;

    // resolved year and day of year
    typedef struct packed {
        logic [SERIAL_W-1:0] sum;
        logic [YEAR_W-1:0]   year;
        logic [DOY_W-1:0]    doy;
        logic                leap;
        status_t             status;
    } cdo_yday_t;

    // n times the reciprocal of 100
    function automatic logic [PROD100_W-1:0] div100_prod(input logic [YEAR_W-1:0] n);
        return PROD100_W'(n) * PROD100_W'(DIV100_MUL);
    endfunction

    // leap years up to year n, given q = floor(n / 100)
    function automatic logic [LU_W-1:0] leaps_upto(input logic [YEAR_W-1:0] n,
                                                   input logic [Q100_W-1:0] q);
        return LU_W'(n[YEAR_W-1:2]) - LU_W'(q) + LU_W'(q[Q100_W-1:2]);
    endfunction

    // length of a month, 0 for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days of the year before the first of month m
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + DOY_W'(leap && (m > 4'd2));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cdo_date2serial.sv -----
// ----------------------------------------------------------------------------
// cdo_date2serial
// Three-stage front end: checks the input date, turns it into a serial day,
// adds the offset and flags a result outside the supported range.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_date2serial import cdo_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [DAY_W-1:0]           s_in_day,
    input  wire logic [MONTH_W-1:0]         s_in_month,
    input  wire logic [YEAR_W-1:0]          s_in_year,
    input  wire logic signed [OFFSET_W-1:0] s_day_offset,
    output logic                            o_valid,
    input  wire logic                       o_ready,
    output cdo_sum_t                        o_data
);

    // stage valids and per-stage ready
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // stage 1: range checks and reciprocal products
    logic [YEAR_W-1:0]          y1_reg;
    logic [MONTH_W-1:0]         m1_reg;
    logic [DAY_W-1:0]           d1_reg;
    logic signed [OFFSET_W-1:0] off1_reg;
    logic [PROD100_W-1:0]       pa1_reg, pb1_reg;
    logic                       pre_ok1_reg;
    logic                       pre_ok_next;
    logic [PROD100_W-1:0]       pa_next, pb_next;

    // stage 2: leap year, day check, serial partial sums
    logic signed [OFFSET_W-1:0] off2_reg;
    logic                       ok2_reg;
    logic [YSERIAL_W-1:0]       ypart2_reg;
    logic [LU_W-1:0]            lpart2_reg;
    logic [LU_W-1:0]            lua, lub;
    logic                       leap;
    logic                       ok2_next;
    logic [YSERIAL_W-1:0]       ypart_next;
    logic [LU_W-1:0]            lpart_next;

    // stage 3: offset add and range check
    logic [SERIAL_W-1:0]        sum3_reg;
    status_t                    st3_reg;
    logic [YSERIAL_W-1:0]       serial;
    logic [SUM_W-1:0]           sum_next;
    logic                       in_range;
    status_t                    st_next;

    // backpressure: a stage loads when empty or when it drains
    assign rdy3    = !v3_reg || o_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // stage 1 logic
    always_comb begin
        pre_ok_next = (int'(s_in_year) >= YEAR_BASE) && (int'(s_in_year) <= LAST_YEAR)
                   && (s_in_month inside {[4'd1:4'd12]}) && (s_in_day != '0);
        pa_next     = div100_prod(s_in_year - YEAR_W'(1));
        pb_next     = div100_prod(s_in_year);
    end

    // stage 2 logic
    always_comb begin
        lua        = leaps_upto(y1_reg - YEAR_W'(1), pa1_reg[PROD100_W-1 -: Q100_W]);
        lub        = leaps_upto(y1_reg, pb1_reg[PROD100_W-1 -: Q100_W]);
        leap       = (lua != lub);
        ok2_next   = pre_ok1_reg && (d1_reg <= month_days(m1_reg, leap));
        ypart_next = YSERIAL_W'(y1_reg - YEAR_W'(YEAR_BASE)) * YSERIAL_W'(DAYS_PER_YEAR);
        lpart_next = (lua - LU_W'(LU_BASE)) + LU_W'(days_before(m1_reg, leap))
                   + LU_W'(d1_reg);
    end

    // stage 3 logic
    always_comb begin
        serial   = ypart2_reg + YSERIAL_W'(lpart2_reg);
        sum_next = SUM_W'(serial) + SUM_W'(off2_reg);
        in_range = !sum_next[SUM_W-1] && (sum_next != '0)
                && (sum_next[SUM_W-2:0] <= (SUM_W-1)'(LAST_SERIAL));
        if (!ok2_reg) begin
            st_next = ST_BAD_DATE;
        end else if (!in_range) begin
            st_next = ST_RANGE;
        end else begin
            st_next = ST_OK;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            y1_reg      <= s_in_year;
            m1_reg      <= s_in_month;
            d1_reg      <= s_in_day;
            off1_reg    <= s_day_offset;
            pa1_reg     <= pa_next;
            pb1_reg     <= pb_next;
            pre_ok1_reg <= pre_ok_next;
        end
        if (rdy2) begin
            off2_reg   <= off1_reg;
            ok2_reg    <= ok2_next;
            ypart2_reg <= ypart_next;
            lpart2_reg <= lpart_next;
        end
        if (rdy3) begin
            sum3_reg <= sum_next[SERIAL_W-1:0];
            st3_reg  <= st_next;
        end
    end

    assign o_valid       = v3_reg;
    assign o_data.sum    = sum3_reg;
    assign o_data.status = st3_reg;

endmodule

`default_nettype wire

// ----- rtl/cdo_serial2year.sv -----
// ----------------------------------------------------------------------------
// cdo_serial2year
// Three-stage year search: estimates the year from the serial day, computes
// the days before it and corrects the estimate by at most one year.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_serial2year import cdo_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      i_valid,
    output logic           i_ready,
    input  wire cdo_sum_t  i_data,
    output logic           o_valid,
    input  wire logic      o_ready,
    output cdo_yday_t      o_data
);

    logic v4_reg, v5_reg, v6_reg;
    logic rdy4, rdy5, rdy6;

    // stage 4: year index estimate, floor((sum - 1) / 365)
    cdo_sum_t             d4_reg;
    logic [YIDX_W-1:0]    c4_reg;
    logic [PROD365_W-1:0] prod365;

    // stage 5: reciprocal products for the estimate and the two years below
    cdo_sum_t             d5_reg;
    logic [YIDX_W-1:0]    c5_reg;
    logic [PROD100_W-1:0] p0_5_reg, p1_5_reg, p2_5_reg;
    logic [YDAYS_W-1:0]   yp5_reg;
    logic [YEAR_W-1:0]    yc4;

    // stage 6: pick the year and the day of year
    cdo_yday_t            d6_reg;
    cdo_yday_t            d6_next;
    logic [YEAR_W-1:0]    yc5;
    logic [LU_W-1:0]      lu0, lu1, lu2;
    logic                 leap_c, leap_p;
    logic [YDAYS_W-1:0]   dc, sum18;

    assign rdy6    = !v6_reg || o_ready;
    assign rdy5    = !v5_reg || rdy6;
    assign rdy4    = !v4_reg || rdy5;
    assign i_ready = rdy4;

    // stage 4 logic
    assign prod365 = PROD365_W'(i_data.sum - SERIAL_W'(1)) * PROD365_W'(DIV365_MUL);

    // stage 5 logic
    assign yc4 = YEAR_W'(YEAR_BASE) + YEAR_W'(c4_reg);

    // stage 6 logic
    always_comb begin
        yc5    = YEAR_W'(YEAR_BASE) + YEAR_W'(c5_reg);
        lu0    = leaps_upto(yc5 - YEAR_W'(2), p0_5_reg[PROD100_W-1 -: Q100_W]);
        lu1    = leaps_upto(yc5 - YEAR_W'(1), p1_5_reg[PROD100_W-1 -: Q100_W]);
        lu2    = leaps_upto(yc5, p2_5_reg[PROD100_W-1 -: Q100_W]);
        leap_c = (lu2 != lu1);
        leap_p = (lu1 != lu0);
        dc     = yp5_reg + YDAYS_W'(lu1) - YDAYS_W'(LU_BASE);
        sum18  = YDAYS_W'(d5_reg.sum);
        d6_next.sum    = d5_reg.sum;
        d6_next.status = d5_reg.status;
        // estimate is one year high when the day falls before its first of January
        if (sum18 > dc) begin
            d6_next.year = yc5;
            d6_next.doy  = DOY_W'(sum18 - dc);
            d6_next.leap = leap_c;
        end else begin
            d6_next.year = yc5 - YEAR_W'(1);
            d6_next.doy  = DOY_W'(sum18 - dc + YDAYS_W'(DAYS_PER_YEAR) + YDAYS_W'(leap_p));
            d6_next.leap = leap_p;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy4) begin
                v4_reg <= i_valid;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rdy4) begin
            d4_reg <= i_data;
            c4_reg <= prod365[PROD365_W-1 -: YIDX_W];
        end
        if (rdy5) begin
            d5_reg   <= d4_reg;
            c5_reg   <= c4_reg;
            p0_5_reg <= div100_prod(yc4 - YEAR_W'(2));
            p1_5_reg <= div100_prod(yc4 - YEAR_W'(1));
            p2_5_reg <= div100_prod(yc4);
            yp5_reg  <= YDAYS_W'(c4_reg) * YDAYS_W'(DAYS_PER_YEAR);
        end
        if (rdy6) begin
            d6_reg <= d6_next;
        end
    end

    assign o_valid = v6_reg;
    assign o_data  = d6_reg;

endmodule

`default_nettype wire

// ----- rtl/cdo_year2date.sv -----
// ----------------------------------------------------------------------------
// cdo_year2date
// Output stage: splits the day of year into month and day, applies the
// status overrides and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_year2date import cdo_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          i_valid,
    output logic               i_ready,
    input  wire cdo_yday_t     i_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [DAY_W-1:0]    m_out_day,
    output logic [MONTH_W-1:0]  m_out_month,
    output logic [YEAR_W-1:0]   m_out_year,
    output logic [SERIAL_W-1:0] m_serial_day,
    output logic [STATUS_W-1:0] m_status
);

    logic                m_valid_reg;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [SERIAL_W-1:0] serial_reg, serial_next;
    logic [STATUS_W-1:0] status_reg;
    logic [MONTH_W-1:0]  mon;
    logic [DAY_W-1:0]    dom;

    assign i_ready = !m_valid_reg || m_ready;

    // month = 1 + number of month starts the day of year lies past
    always_comb begin
        mon = MONTH_W'(1);
        for (int j = 2; j <= 12; j++) begin
            if (i_data.doy > days_before(MONTH_W'(j), i_data.leap)) begin
                mon = mon + MONTH_W'(1);
            end
        end
        dom = DAY_W'(i_data.doy - days_before(mon, i_data.leap));
    end

    // status overrides
    always_comb begin
        case (i_data.status)
            ST_OK: begin
                day_next    = dom;
                month_next  = mon;
                year_next   = i_data.year;
                serial_next = i_data.sum;
            end
            ST_BAD_DATE: begin
                day_next    = DAY_W'(1);
                month_next  = MONTH_W'(1);
                year_next   = YEAR_W'(YEAR_BASE);
                serial_next = '0;
            end
            default: begin
                day_next    = '0;
                month_next  = '0;
                year_next   = '0;
                serial_next = '0;
            end
        endcase
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (i_ready) begin
            m_valid_reg <= i_valid;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (i_ready) begin
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            serial_reg <= serial_next;
            status_reg <= i_data.status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_day    = day_reg;
    assign m_out_month  = month_reg;
    assign m_out_year   = year_reg;
    assign m_serial_day = serial_reg;
    assign m_status     = status_reg;

endmodule

`default_nettype wire

// ----- rtl/calendar_date_day_offset.sv -----
// ----------------------------------------------------------------------------
// calendar_date_day_offset
// Adds a signed day offset to a Gregorian date and returns the new date,
// its serial day (1 Jan 1900 is 1) and a status code.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes a date (day, month, year) and a signed day offset;
//   m_ channel returns day, month, year, serial day and status
//   (0 ok, 1 invalid input date, 2 result outside 1 Jan 1900..31 Dec 2155).
//   Both channels use valid/ready; a transaction moves when both are high.
// Pipeline: seven register stages, three to the serial day, three to
//   resolve the year and one to split month and day.
// Throughput: one transaction per cycle while the m_ channel does not stall.
// Reset: aresetn clears every stage valid bit; the pipeline comes up empty
//   and s_ready is high in the first cycle after reset.
// Stall: while m_ready is low the held result stays stable; earlier stages
//   keep filling their empty slots, and s_ready falls only when all seven
//   stages hold a transaction. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_day_offset import cdo_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [DAY_W-1:0]           s_in_day,
    input  wire logic [MONTH_W-1:0]         s_in_month,
    input  wire logic [YEAR_W-1:0]          s_in_year,
    input  wire logic signed [OFFSET_W-1:0] s_day_offset,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [DAY_W-1:0]                m_out_day,
    output logic [MONTH_W-1:0]              m_out_month,
    output logic [YEAR_W-1:0]               m_out_year,
    output logic [SERIAL_W-1:0]             m_serial_day,
    output logic [STATUS_W-1:0]             m_status
);

    logic      sum_valid, sum_ready;
    cdo_sum_t  sum_data;
    logic      yday_valid, yday_ready;
    cdo_yday_t yday_data;

    // date check, serial day and offset add
    cdo_date2serial u_date2serial (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_day     (s_in_day),
        .s_in_month   (s_in_month),
        .s_in_year    (s_in_year),
        .s_day_offset (s_day_offset),
        .o_valid      (sum_valid),
        .o_ready      (sum_ready),
        .o_data       (sum_data)
    );

    // serial day back to year and day of year
    cdo_serial2year u_serial2year (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (sum_valid),
        .i_ready (sum_ready),
        .i_data  (sum_data),
        .o_valid (yday_valid),
        .o_ready (yday_ready),
        .o_data  (yday_data)
    );

    // month and day split, output register
    cdo_year2date u_year2date (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .i_valid      (yday_valid),
        .i_ready      (yday_ready),
        .i_data       (yday_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_day    (m_out_day),
        .m_out_month  (m_out_month),
        .m_out_year   (m_out_year),
        .m_serial_day (m_serial_day),
        .m_status     (m_status)
    );

    // a good result carries a real calendar date and a nonzero serial day
    a_ok_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_OK)) |->
            ((m_out_month >= 4'd1) && (m_out_month <= 4'd12) && (m_out_day != '0)
             && (m_serial_day != '0) && (int'(m_out_year) >= YEAR_BASE)))
        else $error("ok result with malformed date");

    // out of range result is all zeros
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_RANGE)) |->
            ((m_out_day == '0) && (m_out_month == '0) && (m_out_year == '0)
             && (m_serial_day == '0)))
        else $error("range error result not cleared");

    // invalid input date maps to 1 Jan 1900 with serial zero
    a_bad_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_BAD_DATE)) |->
            ((m_out_day == DAY_W'(1)) && (m_out_month == MONTH_W'(1))
             && (m_out_year == YEAR_W'(YEAR_BASE)) && (m_serial_day == '0)))
        else $error("invalid date result mismatch");

    // serial day never exceeds the last supported day
    a_serial_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_serial_day) <= LAST_SERIAL))
        else $error("serial day beyond last supported day");

endmodule

`default_nettype wire

// ----- tb/calendar_date_day_offset_test.sv -----
// ----------------------------------------------------------------------------
// calendar_date_day_offset_test
// Self-checking testbench for the date plus day offset pipeline. A directed
// table covers calendar edges, leap-year rules, invalid dates and range
// errors, then random dates and offsets follow. Each result transaction is
// checked against a table result or a behavioral date predictor, with random
// idle bursts on both channels.
// ----------------------------------------------------------------------------
module calendar_date_day_offset_test import cdo_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [SERIAL_W-1:0] serial;
        status_t             status;
    } date_result_t;

    typedef struct packed {
        logic [DAY_W-1:0]           day;
        logic [MONTH_W-1:0]         month;
        logic [YEAR_W-1:0]          year;
        logic signed [OFFSET_W-1:0] offset;
        logic                       typed;
        date_result_t               want;
    } date_row_t;

    localparam date_result_t BAD_DATE_RES = '{5'd1, 4'd1, 12'd1900, 17'd0, ST_BAD_DATE};
    localparam date_result_t RANGE_RES    = '{5'd0, 4'd0, 12'd0, 17'd0, ST_RANGE};
    localparam date_result_t FIRST_RES    = '{5'd1, 4'd1, 12'd1900, 17'd1, ST_OK};
    localparam date_result_t NO_RES       = '0;

    localparam int DIRECTED_ROWS = 24;

    // directed cases: typed rows carry their result, others use the predictor
    date_row_t directed_rows [DIRECTED_ROWS] = '{
        '{5'd1,  4'd1,  12'd1900, 18'sd0,       1'b1, FIRST_RES},
        '{5'd31, 4'd12, 12'd2155, 18'sd0,       1'b0, NO_RES},
        '{5'd1,  4'd1,  12'd1900, -18'sd1,      1'b1, RANGE_RES},
        '{5'd31, 4'd12, 12'd2155, 18'sd1,       1'b1, RANGE_RES},
        '{5'd1,  4'd1,  12'd1900, 18'sd131071,  1'b1, RANGE_RES},
        '{5'd31, 4'd12, 12'd2155, 18'sh20000,   1'b1, RANGE_RES},
        '{5'd1,  4'd1,  12'd1900, 18'sd93501,   1'b0, NO_RES},
        '{5'd31, 4'd12, 12'd2155, -18'sd93501,  1'b0, NO_RES},
        '{5'd29, 4'd2,  12'd1900, 18'sd0,       1'b1, BAD_DATE_RES},
        '{5'd29, 4'd2,  12'd2000, 18'sd0,       1'b0, NO_RES},
        '{5'd29, 4'd2,  12'd2100, 18'sd0,       1'b1, BAD_DATE_RES},
        '{5'd29, 4'd2,  12'd2004, 18'sd365,     1'b0, NO_RES},
        '{5'd0,  4'd1,  12'd2000, 18'sd0,       1'b1, BAD_DATE_RES},
        '{5'd31, 4'd4,  12'd2000, 18'sd0,       1'b1, BAD_DATE_RES},
        '{5'd1,  4'd0,  12'd2000, 18'sd0,       1'b1, BAD_DATE_RES},
        '{5'd1,  4'd13, 12'd2000, 18'sd0,       1'b1, BAD_DATE_RES},
        '{5'd31, 4'd15, 12'd4095, -18'sd1,      1'b1, BAD_DATE_RES},
        '{5'd1,  4'd1,  12'd1899, 18'sd0,       1'b1, BAD_DATE_RES},
        '{5'd1,  4'd1,  12'd2156, 18'sd0,       1'b1, BAD_DATE_RES},
        '{5'd1,  4'd1,  12'd0,    18'sd131071,  1'b1, BAD_DATE_RES},
        '{5'd28, 4'd2,  12'd1900, 18'sd1,       1'b0, NO_RES},
        '{5'd31, 4'd12, 12'd1999, 18'sd1,       1'b0, NO_RES},
        '{5'd15, 4'd6,  12'd2024, -18'sd36500,  1'b0, NO_RES},
        '{5'd30, 4'd11, 12'd2155, 18'sd31,      1'b0, NO_RES}
    };

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [DAY_W-1:0]           s_in_day;
    logic [MONTH_W-1:0]         s_in_month;
    logic [YEAR_W-1:0]          s_in_year;
    logic signed [OFFSET_W-1:0] s_day_offset;
    logic                       m_valid;
    logic                       m_ready;
    logic [DAY_W-1:0]           m_out_day;
    logic [MONTH_W-1:0]         m_out_month;
    logic [YEAR_W-1:0]          m_out_year;
    logic [SERIAL_W-1:0]        m_serial_day;
    logic [STATUS_W-1:0]        m_status;

    date_result_t pending_dates [$];
    int           err_count;
    int           cycle_count;
    int           last_serial;
    bit           quiet;
    bit           gap_mode;

    calendar_date_day_offset u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_day     (s_in_day),
        .s_in_month   (s_in_month),
        .s_in_year    (s_in_year),
        .s_day_offset (s_day_offset),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_day    (m_out_day),
        .m_out_month  (m_out_month),
        .m_out_year   (m_out_year),
        .m_serial_day (m_serial_day),
        .m_status     (m_status)
    );

    // gregorian leap-year rule
    function automatic bit is_leap_year(input int y);
        if (y % 400 == 0) return 1'b1;
        if (y % 100 == 0) return 1'b0;
        return (y % 4) == 0;
    endfunction

    function automatic int month_length(input int y, input int m);
        case (m)
            2:             return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic int year_length(input int y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    // serial day of a valid date, 1 Jan of the base year is 1
    function automatic int serial_of_date(input int d, input int m, input int y);
        int s;
        s = 0;
        for (int yy = YEAR_BASE; yy < y; yy++) s += year_length(yy);
        for (int mm = 1; mm < m; mm++) s += month_length(y, mm);
        return s + d;
    endfunction

    // expected result of one date plus offset transaction
    function automatic date_result_t add_day_offset(input logic [DAY_W-1:0] d,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [YEAR_W-1:0] y,
                                                    input logic signed [OFFSET_W-1:0] off);
        date_result_t r;
        int           sum;
        int           rest;
        int           yy;
        int           mm;
        if (y < YEAR_BASE || y > LAST_YEAR || m < 1 || m > 12 || d < 1 ||
            d > month_length(int'(y), int'(m))) begin
            return BAD_DATE_RES;
        end
        sum = serial_of_date(int'(d), int'(m), int'(y)) + int'(off);
        if (sum < 1 || sum > last_serial) begin
            return RANGE_RES;
        end
        // walk years then months down to the day
        rest = sum;
        yy   = YEAR_BASE;
        mm   = 1;
        while (rest > year_length(yy)) begin
            rest -= year_length(yy);
            yy++;
        end
        while (mm < 12 && rest > month_length(yy, mm)) begin
            rest -= month_length(yy, mm);
            mm++;
        end
        r.day    = DAY_W'(rest);
        r.month  = MONTH_W'(mm);
        r.year   = YEAR_W'(yy);
        r.serial = SERIAL_W'(sum);
        r.status = ST_OK;
        return r;
    endfunction

    // drive one transaction and record its expected result on acceptance
    task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                             input logic [YEAR_W-1:0] y,
                             input logic signed [OFFSET_W-1:0] off,
                             input date_result_t want);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_in_day     <= d;
        s_in_month   <= m;
        s_in_year    <= y;
        s_day_offset <= off;
        do @(posedge aclk); while (!s_ready);
        pending_dates.push_back(want);
    endtask

    // random idle burst on the input side, switched on and off in stretches
    task automatic maybe_gap();
        if ($urandom_range(0, 63) == 0) gap_mode = !gap_mode;
        if (!quiet && gap_mode && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 16)) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // result side ready with random stall bursts
    initial begin
        int  stall_left;
        bit  stall_mode;
        stall_left = 0;
        stall_mode = 1'b1;
        m_ready    = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 127) == 0) stall_mode = !stall_mode;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && stall_mode && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        date_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dates.size() == 0) begin
                $error("unexpected result transaction: day %0d month %0d year %0d",
                       m_out_day, m_out_month, m_out_year);
                err_count++;
            end else begin
                exp_res = pending_dates.pop_front();
                if (m_out_day !== exp_res.day) begin
                    $error("out_day: expected %0d, got %0d", exp_res.day, m_out_day);
                    err_count++;
                end
                if (m_out_month !== exp_res.month) begin
                    $error("out_month: expected %0d, got %0d", exp_res.month, m_out_month);
                    err_count++;
                end
                if (m_out_year !== exp_res.year) begin
                    $error("out_year: expected %0d, got %0d", exp_res.year, m_out_year);
                    err_count++;
                end
                if (m_serial_day !== exp_res.serial) begin
                    $error("serial_day: expected %0d, got %0d", exp_res.serial, m_serial_day);
                    err_count++;
                end
                if (m_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_status);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [DAY_W-1:0]           d;
        logic [MONTH_W-1:0]         m;
        logic [YEAR_W-1:0]          y;
        logic signed [OFFSET_W-1:0] off;
        int                         kind;
        int                         start;
        int                         dim;
        date_result_t               want;

        err_count    = 0;
        quiet        = 1'b0;
        gap_mode     = 1'b1;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_in_day     = '0;
        s_in_month   = '0;
        s_in_year    = '0;
        s_day_offset = '0;
        last_serial  = serial_of_date(31, 12, LAST_YEAR);
        if (last_serial > SERIAL_MAX) last_serial = SERIAL_MAX;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            maybe_gap();
            want = directed_rows[i].typed ? directed_rows[i].want
                 : add_day_offset(directed_rows[i].day, directed_rows[i].month,
                                  directed_rows[i].year, directed_rows[i].offset);
            send_date(directed_rows[i].day, directed_rows[i].month, directed_rows[i].year,
                      directed_rows[i].offset, want);
        end

        // random dates and offsets
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            maybe_gap();
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                // noise over the whole field range
                d   = DAY_W'($urandom);
                m   = MONTH_W'($urandom);
                y   = YEAR_W'($urandom);
                off = OFFSET_W'($urandom);
            end else begin
                // well-formed year and month, mostly a valid day
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       y = YEAR_W'(YEAR_BASE);
                        1:       y = 12'd2000;
                        2:       y = 12'd2100;
                        default: y = YEAR_W'(LAST_YEAR);
                    endcase
                end else begin
                    y = YEAR_W'($urandom_range(YEAR_BASE, LAST_YEAR));
                end
                m   = MONTH_W'($urandom_range(1, 12));
                dim = month_length(int'(y), int'(m));
                if (kind < 16) begin
                    // day past the end of the month, or zero
                    d = (dim == 31) ? '0 : DAY_W'($urandom_range(dim + 1, 31));
                end else begin
                    d = DAY_W'($urandom_range(1, dim));
                end
                start = serial_of_date(int'(d), int'(m), int'(y));
                case ($urandom_range(0, 4))
                    0:       off = OFFSET_W'(int'($urandom_range(0, 800)) - 400);
                    1:       off = OFFSET_W'(int'($urandom_range(0, 80000)) - 40000);
                    2:       off = OFFSET_W'($urandom);
                    3:       off = OFFSET_W'(1 - start + int'($urandom_range(0, 4)) - 2);
                    default: off = OFFSET_W'(last_serial - start + int'($urandom_range(0, 4)) - 2);
                endcase
            end
            send_date(d, m, y, off, add_day_offset(d, m, y, off));
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain the pipeline, then keep watching for stray results
        while (pending_dates.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0 && pending_dates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
